// File: src/firewall_rule_table_top_macros.svh
// Assertion helpers used by firewall_rule_table_top.sv.
`ifndef FIREWALL_RULE_TABLE_TOP_MACROS_SVH
`define FIREWALL_RULE_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FWRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FWRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/fwrt_pkg.sv
package fwrt_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;

   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_EXISTS    = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_DELETED   = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_ACCEPTED  = 3'd5;
   localparam logic [2:0] ST_REJECTED  = 3'd6;

   typedef struct packed {
      logic [31:0] ip_low;
      logic [31:0] ip_high;
      logic [15:0] port_low;
      logic [15:0] port_high;
   } fwrt_rule_type;

   // Commands broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic compare;
      logic write;
      logic shift;
      logic bump;
   } fwrt_ctl_type;

endpackage

// File: src/fwrt_if.sv
interface fwrt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] rule_ip_low;
   logic [31:0] rule_ip_high;
   logic [15:0] rule_port_low;
   logic [15:0] rule_port_high;
   logic [31:0] packet_ip;
   logic [15:0] packet_port;

   modport source (
      output valid, operation, rule_ip_low, rule_ip_high, rule_port_low,
             rule_port_high, packet_ip, packet_port,
      input  ready
   );
   modport sink (
      input  valid, operation, rule_ip_low, rule_ip_high, rule_port_low,
             rule_port_high, packet_ip, packet_port,
      output ready
   );
endinterface

interface fwrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  matched_slot;
   logic [15:0] hit_total;

   modport source (
      output valid, status, matched_slot, hit_total,
      input  ready
   );
   modport sink (
      input  valid, status, matched_slot, hit_total,
      output ready
   );
endinterface

// File: src/firewall_rule_table_top.sv
// Channel   Direction  Carries
// req_bus   in         operation, rule bounds, packet address and port
// rsp_bus   out        status, matched_slot, hit_total
//
// After an item is accepted, every cell compares, a priority pick is made over the row, the
// cells update, and the hit counter is read into the output register once that register is free.
// The next item is taken only after the result is loaded, so one item is in flight at a time.
// Reset is synchronous and clears the sequencer, the rule count and the output valid.
// A result waiting on rsp_bus holds the next item in its last step until it is taken.
`include "firewall_rule_table_top_macros.svh"

module firewall_rule_table_top import fwrt_pkg::*; #(
   parameter int RULE_SLOTS = 64,
   parameter int HIT_BITS   = 16
) (
   input logic          clock,
   input logic          reset,
   fwrt_req_if.sink     req_bus,
   fwrt_rsp_if.source   rsp_bus
);

   localparam int CNT_W = $clog2(RULE_SLOTS + 1);
   localparam int IDX_W = $clog2(RULE_SLOTS);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CMP  = 5'b00010,
      S_PICK = 5'b00100,
      S_EXEC = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           op_ff;
   fwrt_rule_type        key_ff;
   logic [31:0]          pip_ff;
   logic [15:0]          pport_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 found_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [2:0]           status_ff;
   logic [IDX_W-1:0]     slot_ff;
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [5:0]           rsp_slot_ff;
   logic [15:0]          rsp_hits_ff;

   fwrt_ctl_type         ctl;
   fwrt_rule_type        rules   [RULE_SLOTS+1];
   logic [HIT_BITS-1:0]  hits    [RULE_SLOTS+1];
   logic [RULE_SLOTS-1:0] match_vec, same_vec;

   logic                 same_any, match_any, full;
   logic [IDX_W-1:0]     same_idx, match_idx;
   logic [HIT_BITS-1:0]  hits_pick;
   logic [31:0]          hits_wide, slot_wide;
   logic                 accept, rsp_load;

   assign accept   = req_bus.valid && req_bus.ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   assign full     = count_ff == CNT_W'(RULE_SLOTS);

   assign ctl.compare = state_ff == S_CMP;
   assign ctl.write   = (state_ff == S_EXEC) && (op_ff == OP_ADD) && !found_ff && !full;
   assign ctl.shift   = (state_ff == S_EXEC) && (op_ff == OP_DELETE) && found_ff;
   assign ctl.bump    = (state_ff == S_EXEC) && (op_ff == OP_CHECK) && found_ff;

   // The row ends in an empty neighbor, so the last cell shifts in nothing useful.
   assign rules[RULE_SLOTS] = '0;
   assign hits[RULE_SLOTS]  = '0;

   for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
      fwrt_cell #(
         .RULE_SLOTS (RULE_SLOTS),
         .HIT_BITS   (HIT_BITS),
         .SLOT       (g)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .key       (key_ff),
         .pkt_ip    (pip_ff),
         .pkt_port  (pport_ff),
         .count     (count_ff),
         .sel       (idx_ff),
         .next_rule (rules[g+1]),
         .next_hits (hits[g+1]),
         .rule_out  (rules[g]),
         .hits_out  (hits[g]),
         .match_out (match_vec[g]),
         .same_out  (same_vec[g])
      );
   end

   // Lowest set flag wins: scan downward so the last assignment is the first slot.
   always_comb begin
      same_any  = 1'b0;
      match_any = 1'b0;
      same_idx  = '0;
      match_idx = '0;
      for (int k = RULE_SLOTS - 1; k >= 0; k--) begin
         if (same_vec[k]) begin
            same_any = 1'b1;
            same_idx = IDX_W'(k);
         end
         if (match_vec[k]) begin
            match_any = 1'b1;
            match_idx = IDX_W'(k);
         end
      end
   end

   always_comb begin
      hits_pick = '0;
      for (int k = 0; k < RULE_SLOTS; k++) begin
         if (idx_ff == IDX_W'(k)) begin
            hits_pick = hits_pick | hits[k];
         end
      end
   end

   assign hits_wide = 32'(hits_pick);
   assign slot_wide = 32'(slot_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CMP;
            end
         end
         S_CMP:  state_in = S_PICK;
         S_PICK: state_in = S_EXEC;
         S_EXEC: state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.write) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.shift) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff            <= req_bus.operation;
         key_ff.ip_low    <= req_bus.rule_ip_low;
         key_ff.ip_high   <= req_bus.rule_ip_high;
         key_ff.port_low  <= req_bus.rule_port_low;
         key_ff.port_high <= req_bus.rule_port_high;
         pip_ff           <= req_bus.packet_ip;
         pport_ff         <= req_bus.packet_port;
      end
      if (state_ff == S_PICK) begin
         if (op_ff == OP_CHECK) begin
            found_ff <= match_any;
            idx_ff   <= match_idx;
         end else begin
            found_ff <= same_any;
            idx_ff   <= same_idx;
         end
      end
      if (state_ff == S_EXEC) begin
         status_ff <= ST_REJECTED;
         slot_ff   <= '0;
         case (op_ff)
            OP_ADD: begin
               if (found_ff) begin
                  status_ff <= ST_EXISTS;
                  slot_ff   <= idx_ff;
               end else if (full) begin
                  status_ff <= ST_FULL;
               end else begin
                  status_ff <= ST_ADDED;
                  slot_ff   <= count_ff[IDX_W-1:0];
               end
            end
            OP_DELETE: begin
               if (found_ff) begin
                  status_ff <= ST_DELETED;
                  slot_ff   <= idx_ff;
               end else begin
                  status_ff <= ST_NOT_FOUND;
               end
            end
            OP_CHECK: begin
               if (found_ff) begin
                  status_ff <= ST_ACCEPTED;
                  slot_ff   <= idx_ff;
               end
            end
            default: begin
               status_ff <= ST_REJECTED;
            end
         endcase
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= slot_wide[5:0];
         rsp_hits_ff   <= (status_ff == ST_ACCEPTED) ? hits_wide[15:0] : 16'd0;
      end
   end

   assign req_bus.ready        = state_ff == S_IDLE;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.matched_slot = rsp_slot_ff;
   assign rsp_bus.hit_total    = rsp_hits_ff;

   `FWRT_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(RULE_SLOTS), "rule count exceeds table size")
   `FWRT_ASSERT_NEXT(a_count_exec_only, clock, reset, state_ff != S_EXEC,
      $stable(count_ff), "rule count changed outside update")
   `FWRT_ASSERT_IMPL(a_added_nonempty, clock, reset, rsp_load && (status_ff == ST_ADDED),
      count_ff != '0, "added reported with empty table")
   `FWRT_ASSERT_IMPL(a_one_update, clock, reset, 1'b1,
      $onehot0({ctl.write, ctl.shift, ctl.bump}), "more than one row update at once")

endmodule

// File: src/fwrt_cell.sv
module fwrt_cell import fwrt_pkg::*; #(
   parameter int RULE_SLOTS = 64,
   parameter int HIT_BITS   = 16,
   parameter int SLOT       = 0
) (
   input  logic                                   clock,
   input  fwrt_ctl_type                           ctl,
   input  fwrt_rule_type                          key,
   input  logic [31:0]                            pkt_ip,
   input  logic [15:0]                            pkt_port,
   input  logic [$clog2(RULE_SLOTS+1)-1:0]        count,
   input  logic [$clog2(RULE_SLOTS)-1:0]          sel,
   input  fwrt_rule_type                          next_rule,
   input  logic [HIT_BITS-1:0]                    next_hits,
   output fwrt_rule_type                          rule_out,
   output logic [HIT_BITS-1:0]                    hits_out,
   output logic                                   match_out,
   output logic                                   same_out
);

   localparam int CNT_W = $clog2(RULE_SLOTS + 1);
   localparam int IDX_W = $clog2(RULE_SLOTS);
   localparam logic [CNT_W-1:0] SLOT_C = CNT_W'(SLOT);
   localparam logic [CNT_W-1:0] SLOT_N = CNT_W'(SLOT + 1);
   localparam logic [IDX_W-1:0] SLOT_I = IDX_W'(SLOT);
   localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

   fwrt_rule_type        rule_ff, rule_in;
   logic [HIT_BITS-1:0]  hits_ff, hits_in;
   logic                 match_ff, match_in;
   logic                 same_ff, same_in;
   logic                 live;

   assign live = SLOT_C < count;

   always_comb begin
      rule_in  = rule_ff;
      hits_in  = hits_ff;
      match_in = match_ff;
      same_in  = same_ff;
      if (ctl.compare) begin
         match_in = live && (pkt_ip >= rule_ff.ip_low) && (pkt_ip <= rule_ff.ip_high) &&
                    (pkt_port >= rule_ff.port_low) && (pkt_port <= rule_ff.port_high);
         same_in  = live && (rule_ff == key);
      end
      if (ctl.write && (SLOT_C == count)) begin
         rule_in = key;
         hits_in = '0;
      end
      // A delete pulls every later rule one place toward the head of the row.
      if (ctl.shift && (SLOT_I >= sel) && (SLOT_N < count)) begin
         rule_in = next_rule;
         hits_in = next_hits;
      end
      if (ctl.bump && (SLOT_I == sel) && (hits_ff != HIT_MAX)) begin
         hits_in = hits_ff + HIT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      rule_ff  <= rule_in;
      hits_ff  <= hits_in;
      match_ff <= match_in;
      same_ff  <= same_in;
   end

   assign rule_out  = rule_ff;
   assign hits_out  = hits_ff;
   assign match_out = match_ff;
   assign same_out  = same_ff;

endmodule

// File: tb/sv/tb_firewall_rule_table_top.sv
module tb_firewall_rule_table_top;
   import fwrt_pkg::*;

   localparam int          SLOTS        = 64;
   localparam logic [15:0] HIT_MAX      = 16'hFFFF;
   localparam logic [1:0]  OP_SPARE     = 2'd3;
   localparam int          RANDOM_ITEMS = 880;
   localparam int          HOT_CHECKS   = 40;
   localparam int          CYCLE_LIMIT  = 2_000_000;

   typedef struct packed {
      logic [1:0]    op;
      fwrt_rule_type rule;
      logic [31:0]   pkt_ip;
      logic [15:0]   pkt_port;
   } fw_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot;
      logic [15:0] hits;
   } fw_result_type;

   // Mirror of the rule table: updated on every accepted item, it queues the
   // verdict the block must return for that item.
   class rule_table_mirror;
      fwrt_rule_type rules [SLOTS];
      logic [15:0]   hits [SLOTS];
      int            count;
      fw_result_type verdict_q [$];
      int            errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function int find_rule(fwrt_rule_type r);
         for (int k = 0; k < count; k++) begin
            if (rules[k] == r) return k;
         end
         return -1;
      endfunction

      function void apply_request(fw_req_type it);
         fw_result_type res;
         int            at;
         res.status = ST_REJECTED;
         res.slot   = '0;
         res.hits   = '0;
         at = find_rule(it.rule);
         case (it.op)
            OP_ADD: begin
               if (at >= 0) begin
                  res.status = ST_EXISTS;
                  res.slot   = 6'(at);
               end else if (count >= SLOTS) begin
                  res.status = ST_FULL;
               end else begin
                  rules[count] = it.rule;
                  hits[count]  = '0;
                  res.status   = ST_ADDED;
                  res.slot     = 6'(count);
                  count++;
               end
            end
            OP_DELETE: begin
               if (at < 0) begin
                  res.status = ST_NOT_FOUND;
               end else begin
                  for (int k = at; k < count - 1; k++) begin
                     rules[k] = rules[k + 1];
                     hits[k]  = hits[k + 1];
                  end
                  count--;
                  res.status = ST_DELETED;
                  res.slot   = 6'(at);
               end
            end
            OP_CHECK: begin
               // The first rule in table order that covers the packet wins.
               for (int k = 0; k < count; k++) begin
                  if (res.status != ST_ACCEPTED &&
                      it.pkt_ip >= rules[k].ip_low && it.pkt_ip <= rules[k].ip_high &&
                      it.pkt_port >= rules[k].port_low &&
                      it.pkt_port <= rules[k].port_high) begin
                     if (hits[k] != HIT_MAX) hits[k]++;
                     res.status = ST_ACCEPTED;
                     res.slot   = 6'(k);
                     res.hits   = hits[k];
                  end
               end
            end
            default: ;
         endcase
         verdict_q.push_back(res);
      endfunction

      function void report(string field, logic [15:0] want, logic [15:0] got);
         errors++;
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
      endfunction

      function void take_verdict(fw_result_type got);
         fw_result_type want;
         if (verdict_q.size() == 0) begin
            errors++;
            $error("unexpected result: status %0d slot %0d hit_total %0d",
                   got.status, got.slot, got.hits);
            return;
         end
         want = verdict_q.pop_front();
         if (got.status !== want.status) report("status", want.status, got.status);
         if (got.slot !== want.slot) report("matched_slot", want.slot, got.slot);
         if (got.hits !== want.hits) report("hit_total", want.hits, got.hits);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   quiet = 1'b0;
   int   cycles = 0;

   rule_table_mirror mirror = new();

   fwrt_req_if req_bus();
   fwrt_rsp_if rsp_bus();

   firewall_rule_table_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin : take_result
      fw_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status = rsp_bus.status;
         got.slot   = rsp_bus.matched_slot;
         got.hits   = rsp_bus.hit_total;
         mirror.take_verdict(got);
      end
   end

   // Result side back-pressure: random stall bursts, none once quiet is set.
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
   endfunction

   function automatic fw_req_type make_item(logic [1:0] op, logic [31:0] il, logic [31:0] ih,
                                            logic [15:0] pl, logic [15:0] ph,
                                            logic [31:0] pip, logic [15:0] pport);
      fw_req_type it;
      it.op             = op;
      it.rule.ip_low    = il;
      it.rule.ip_high   = ih;
      it.rule.port_low  = pl;
      it.rule.port_high = ph;
      it.pkt_ip         = pip;
      it.pkt_port       = pport;
      return it;
   endfunction

   // Returns {low, high} within 0..top: single values, short spans, wide spans,
   // the whole space, or an inverted pair.
   function automatic logic [63:0] random_range(logic [31:0] top);
      logic [31:0] a, b, t;
      logic [32:0] sum;
      a = $urandom & top;
      b = $urandom & top;
      if (a > b) begin
         t = a;
         a = b;
         b = t;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: b = a;
         3, 4, 5: begin
            sum = {1'b0, a} + 33'($urandom_range(1, 300));
            b = (sum > {1'b0, top}) ? top : sum[31:0];
         end
         6: begin
            a = '0;
            b = top;
         end
         7: begin
            if (a != b) begin
               t = a;
               a = b;
               b = t;
            end
         end
         default: ;
      endcase
      return {a, b};
   endfunction

   function automatic fwrt_rule_type random_rule();
      fwrt_rule_type r;
      logic [63:0]   ips, ports;
      ips   = random_range(32'hFFFF_FFFF);
      ports = random_range(32'h0000_FFFF);
      r.ip_low    = ips[63:32];
      r.ip_high   = ips[31:0];
      r.port_low  = ports[47:32];
      r.port_high = ports[15:0];
      return r;
   endfunction

   // A point on, just outside, or inside the range lo..hi.
   function automatic logic [31:0] point_near(logic [31:0] lo, logic [31:0] hi,
                                              logic [31:0] top);
      logic [63:0] span;
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         2: return (lo != 0) ? lo - 1 : lo;
         3: return (hi != top) ? hi + 1 : hi;
         default: begin
            if (lo > hi) return $urandom & top;
            span = {32'd0, hi} - {32'd0, lo} + 64'd1;
            return lo + 32'({$urandom, $urandom} % span);
         end
      endcase
   endfunction

   // While growing, adds dominate until the table is full; while shrinking,
   // deletes dominate until it is nearly empty.
   function automatic fw_req_type next_item(bit growing);
      fw_req_type    it;
      fwrt_rule_type r;
      int            k, pick, t1, t2, t3, t4, t5, t6;
      it.op       = OP_CHECK;
      it.rule     = random_rule();
      it.pkt_ip   = $urandom;
      it.pkt_port = 16'($urandom);
      k  = (mirror.count > 0) ? $urandom_range(0, mirror.count - 1) : 0;
      r  = mirror.rules[k];
      t1 = growing ? 40 : 8;
      t2 = t1 + 6;
      t3 = t2 + (growing ? 8 : 35);
      t4 = t3 + 5;
      t5 = t4 + 30;
      t6 = t5 + 10;
      pick = $urandom_range(0, t6 + 3);
      if (pick < t1) begin
         it.op = OP_ADD;
      end else if (pick < t2) begin
         it.op = OP_ADD;
         if (mirror.count > 0) it.rule = r;
      end else if (pick < t3) begin
         it.op = OP_DELETE;
         if (mirror.count > 0) it.rule = r;
      end else if (pick < t4) begin
         // A random rule or, half the time, one that differs from a stored one in a single bit.
         it.op = OP_DELETE;
         if (mirror.count > 0 && $urandom_range(0, 1) == 1) begin
            it.rule = r;
            it.rule[$urandom_range(0, 95)] ^= 1'b1;
         end
      end else if (pick < t5) begin
         if (mirror.count > 0) begin
            it.pkt_ip   = point_near(r.ip_low, r.ip_high, 32'hFFFF_FFFF);
            it.pkt_port = 16'(point_near(r.port_low, r.port_high, 32'h0000_FFFF));
         end
      end else if (pick >= t6) begin
         it.op = OP_SPARE;
      end
      return it;
   endfunction

   task automatic send_item(fw_req_type it, int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= it.op;
      req_bus.rule_ip_low    <= it.rule.ip_low;
      req_bus.rule_ip_high   <= it.rule.ip_high;
      req_bus.rule_port_low  <= it.rule.port_low;
      req_bus.rule_port_high <= it.rule.port_high;
      req_bus.packet_ip      <= it.pkt_ip;
      req_bus.packet_port    <= it.pkt_port;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      mirror.apply_request(it);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (mirror.verdict_q.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      fwrt_rule_type target;
      bit            growing;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.operation      <= OP_ADD;
      req_bus.rule_ip_low    <= '0;
      req_bus.rule_ip_high   <= '0;
      req_bus.rule_port_low  <= '0;
      req_bus.rule_port_high <= '0;
      req_bus.packet_ip      <= '0;
      req_bus.packet_port    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty table, the unused operation, then the extremes of the bounds.
      send_item(make_item(OP_CHECK, 0, 0, 0, 0, 0, 0), draw_gap());
      send_item(make_item(OP_DELETE, 32'h0102_0304, 32'h0102_0304, 22, 22, 0, 0), draw_gap());
      send_item(make_item(OP_SPARE, '1, '1, '1, '1, '1, '1), draw_gap());
      send_item(make_item(OP_ADD, 0, 0, 0, 0, 0, 0), draw_gap());
      send_item(make_item(OP_ADD, 0, '1, 0, '1, 0, 0), draw_gap());
      send_item(make_item(OP_ADD, 0, '1, 0, '1, '1, '1), draw_gap());
      // Inverted ranges never match.
      send_item(make_item(OP_ADD, '1, 0, '1, 0, 0, 0), draw_gap());
      send_item(make_item(OP_CHECK, 0, 0, 0, 0, 0, 0), draw_gap());
      send_item(make_item(OP_CHECK, 0, 0, 0, 0, '1, '1), draw_gap());
      send_item(make_item(OP_CHECK, 0, 0, 0, 0, 0, 1), draw_gap());
      send_item(make_item(OP_ADD, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 16'h1F90, 16'h1F90, 0, 0),
                draw_gap());
      send_item(make_item(OP_ADD, 0, '1, 0, 16'hFFFE, 0, 0), draw_gap());
      // Deleting slot 0 moves the hit counts along with the rules.
      send_item(make_item(OP_DELETE, 0, 0, 0, 0, 0, 0), draw_gap());
      send_item(make_item(OP_CHECK, 0, 0, 0, 0, 0, 0), draw_gap());
      send_item(make_item(OP_DELETE, 1, '1, 0, '1, 0, 0), draw_gap());
      send_item(make_item(OP_DELETE, 0, '1, 0, '1, 0, 0), draw_gap());
      send_item(make_item(OP_CHECK, 0, 0, 0, 0, 32'hA5A5_A5A5, 16'h1F90), draw_gap());
      send_item(make_item(OP_CHECK, 0, 0, 0, 0, 32'hA5A5_A5A5, 16'hFFFF), draw_gap());
      send_item(make_item(OP_CHECK, 0, 0, 0, 0, 32'h1234_5678, 16'hFFFE), draw_gap());
      send_item(make_item(OP_SPARE, $urandom, $urandom, 16'($urandom), 16'($urandom),
                          $urandom, 16'($urandom)), draw_gap());
      send_item(make_item(OP_CHECK, '1, '1, '1, '1, 32'h8000_0000, 16'h8000), draw_gap());
      wait_drained();

      growing = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (mirror.count >= SLOTS) growing = 1'b0;
         else if (mirror.count <= 4) growing = 1'b1;
         send_item(next_item(growing), ((n / 120) % 4 == 3) ? 0 : draw_gap());
         if (n == RANDOM_ITEMS / 2) wait_drained();
      end
      wait_drained();

      // Hammer the first rule's hit counter with back-to-back checks and no idling.
      quiet = 1'b1;
      while (mirror.count > 0 && (mirror.rules[0].ip_low > mirror.rules[0].ip_high ||
             mirror.rules[0].port_low > mirror.rules[0].port_high)) begin
         target = mirror.rules[0];
         send_item(make_item(OP_DELETE, target.ip_low, target.ip_high, target.port_low,
                             target.port_high, 0, 0), 0);
      end
      if (mirror.count == 0) begin
         send_item(make_item(OP_ADD, 32'h0A00_0000, 32'h0AFF_FFFF, 1, 1023, 0, 0), 0);
      end
      target = mirror.rules[0];
      repeat (HOT_CHECKS) begin
         send_item(make_item(OP_CHECK, 0, 0, 0, 0, target.ip_high, target.port_low), 0);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mirror.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
